FILE: rtl/r3df_pkg.sv
// shared types, constants and crc-24q byte update for the rtcm3 deframer
`default_nettype none

package r3df_pkg;

   localparam logic [7:0]  PREAMBLE_BYTE = 8'hD3;
   localparam logic [24:0] CRC24Q_POLY   = 25'h1864CFB;
   localparam logic [7:0]  RESERVED_MASK = 8'hFC;
   localparam logic [7:0]  LEN_HI_MASK   = 8'h03;
   localparam logic [9:0]  TRAILER_LEN   = 10'd3;
   localparam logic [9:0]  TYPE_MIN_LEN  = 10'd2;

   // byte roles as shown on the result channel
   localparam logic [2:0] ROLE_DISCARD  = 3'd0;
   localparam logic [2:0] ROLE_PREAMBLE = 3'd1;
   localparam logic [2:0] ROLE_LENGTH   = 3'd2;
   localparam logic [2:0] ROLE_PAYLOAD  = 3'd3;
   localparam logic [2:0] ROLE_CRC      = 3'd4;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      logic [2:0]  byte_role;
      logic        frame_done;
      logic        crc_good;
      logic [11:0] message_type;
      logic        type_valid;
      logic [9:0]  frame_payload_length;
   } result_type;

   // msb-first crc-24q over one byte, eight xor steps
   function automatic logic [23:0] crc24q_byte(input logic [23:0] acc,
                                               input logic [7:0]  data);
      logic [24:0] c;
      c = {1'b0, acc ^ {data, 16'h0000}};
      for (int k = 0; k < 8; k++) begin
         c = {c[23:0], 1'b0};
         if (c[24]) begin
            c = c ^ CRC24Q_POLY;
         end
      end
      return c[23:0];
   endfunction

   localparam logic [23:0] PREAMBLE_CRC = crc24q_byte(24'h000000, PREAMBLE_BYTE);

endpackage

`default_nettype wire

FILE: rtl/rtcm3_frame_deframer_core.sv
// top level: rtcm3 deframer with crc-24q check, input register and result register
// order: a byte accepted into the input register moves into the result register when
//   the parser advances; that waits while the result register holds a stalled beat
// throughput: one byte per cycle unless rsp_ready stalls; the whole crc-24q byte update
//   and the phase logic fit between the input register and the result register
// reset: synchronous, active high; hunting phase, frame registers and both valid flags clear
`default_nettype none

module rtcm3_frame_deframer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_echo_byte,
   output logic [2:0]       rsp_byte_role,
   output logic             rsp_frame_done,
   output logic             rsp_crc_good,
   output logic [11:0]      rsp_message_type,
   output logic             rsp_type_valid,
   output logic [9:0]       rsp_frame_payload_length
);
   import r3df_pkg::*;

   // input stage: one byte held until the parser moves it on
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser fires when a byte is held and the result register can take a beat
   logic       out_ready;
   logic       advance;
   result_type parse_result;
   result_type out_data;

   assign advance   = in_valid_ff && out_ready;
   // input register frees up in the same cycle its beat moves on
   assign req_ready = !in_valid_ff || out_ready;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // phase machine, crc and result formation
   r3df_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .result    (parse_result)
   );

   // result register decouples the consumer's stalls from the parser
   r3df_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_data  (parse_result),
      .load_ready (out_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_echo_byte            = out_data.echo_byte;
   assign rsp_byte_role            = out_data.byte_role;
   assign rsp_frame_done           = out_data.frame_done;
   assign rsp_crc_good             = out_data.crc_good;
   assign rsp_message_type         = out_data.message_type;
   assign rsp_type_valid           = out_data.type_valid;
   assign rsp_frame_payload_length = out_data.frame_payload_length;

endmodule

`default_nettype wire

FILE: rtl/r3df_parser.sv
// frame phase tracking, crc accumulation and per-byte result generation
`default_nettype none

module r3df_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [7:0]           data_byte,
   output r3df_pkg::result_type      result
);
   import r3df_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [23:0] crc_ff, crc_in;
   logic [9:0]  count_ff, count_in;
   logic [9:0]  length_ff, length_in;
   logic [23:0] check_ff, check_in;
   logic [11:0] type_ff, type_in;

   logic [23:0] crc_next;
   logic [9:0]  count_plus;
   logic [9:0]  length_lo;
   logic [23:0] check_shift;
   logic        hi_ok;

   assign crc_next    = crc24q_byte(crc_ff, data_byte);
   assign count_plus  = count_ff + 10'd1;
   assign length_lo   = length_ff | {2'b00, data_byte};
   assign check_shift = {check_ff[15:0], data_byte};
   assign hi_ok       = (data_byte & RESERVED_MASK) == 8'h00;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_LEN_HI: begin
            if (hi_ok) begin
               phase_in = PH_LEN_LO;
            end else if (data_byte == PREAMBLE_BYTE) begin
               phase_in = PH_LEN_HI;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN_LO: begin
            phase_in = (length_lo == 10'd0) ? PH_CRC : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            phase_in = (count_plus >= length_ff) ? PH_CRC : PH_PAYLOAD;
         end
         PH_CRC: begin
            phase_in = (count_plus >= TRAILER_LEN) ? PH_HUNT : PH_CRC;
         end
         default: begin
            phase_in = (data_byte == PREAMBLE_BYTE) ? PH_LEN_HI : PH_HUNT;
         end
      endcase
   end

   // frame registers and the result of this byte
   always_comb begin
      crc_in    = crc_ff;
      count_in  = count_ff;
      length_in = length_ff;
      check_in  = check_ff;
      type_in   = type_ff;
      result                      = '0;
      result.echo_byte            = data_byte;
      result.byte_role            = ROLE_DISCARD;
      case (phase_ff)
         PH_LEN_HI: begin
            if (hi_ok) begin
               result.byte_role = ROLE_LENGTH;
               length_in        = {data_byte[1:0] & LEN_HI_MASK[1:0], 8'h00};
               crc_in           = crc_next;
            end else if (data_byte == PREAMBLE_BYTE) begin
               result.byte_role = ROLE_PREAMBLE;
               crc_in    = PREAMBLE_CRC;
               count_in  = '0;
               length_in = '0;
               check_in  = '0;
               type_in   = '0;
            end
         end
         PH_LEN_LO: begin
            result.byte_role            = ROLE_LENGTH;
            length_in                   = length_lo;
            crc_in                      = crc_next;
            count_in                    = '0;
            result.frame_payload_length = length_lo;
         end
         PH_PAYLOAD: begin
            result.byte_role = ROLE_PAYLOAD;
            crc_in           = crc_next;
            if (count_ff == 10'd0) begin
               type_in = {data_byte, 4'h0};
            end else if (count_ff == 10'd1) begin
               type_in = {type_ff[11:4], data_byte[7:4]};
            end
            count_in = (count_plus >= length_ff) ? 10'd0 : count_plus;
            result.frame_payload_length = length_ff;
         end
         PH_CRC: begin
            result.byte_role            = ROLE_CRC;
            check_in                    = check_shift;
            count_in                    = count_plus;
            result.frame_payload_length = length_ff;
            if (count_plus >= TRAILER_LEN) begin
               result.frame_done = 1'b1;
               result.crc_good   = check_shift == crc_ff;
               result.type_valid = length_ff >= TYPE_MIN_LEN;
               result.message_type = (length_ff >= TYPE_MIN_LEN) ? type_ff : 12'h000;
               count_in = '0;
            end
         end
         default: begin
            if (data_byte == PREAMBLE_BYTE) begin
               result.byte_role = ROLE_PREAMBLE;
               crc_in    = PREAMBLE_CRC;
               count_in  = '0;
               length_in = '0;
               check_in  = '0;
               type_in   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         crc_ff    <= '0;
         count_ff  <= '0;
         length_ff <= '0;
         check_ff  <= '0;
         type_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         check_ff  <= check_in;
         type_ff   <= type_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/r3df_out_reg.sv
// result register with valid/ready toward the consumer
`default_nettype none

module r3df_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire r3df_pkg::result_type load_data,
   output logic                      load_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output r3df_pkg::result_type      out_data
);
   import r3df_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/r3df_checker.sv
// port-level checks for the rtcm3 deframer, bound to the top level
`default_nettype none

module r3df_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_data_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_echo_byte,
   input wire logic [2:0]  rsp_byte_role,
   input wire logic        rsp_frame_done,
   input wire logic        rsp_crc_good,
   input wire logic [11:0] rsp_message_type,
   input wire logic        rsp_type_valid,
   input wire logic [9:0]  rsp_frame_payload_length
);
   import r3df_pkg::*;

   // frame end only on a crc byte
   a_done_on_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_byte_role == ROLE_CRC)
      else $error("frame_done on a byte that is not a crc byte");

   // pass and type flags and the type itself only come with frame end
   a_flags_need_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_crc_good || rsp_type_valid || rsp_message_type != 12'h000)
      |-> rsp_frame_done)
      else $error("crc_good, type_valid or message_type without frame_done");

   // no length shown outside a frame body
   a_len_outside_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_DISCARD || rsp_byte_role == ROLE_PREAMBLE)
      |-> rsp_frame_payload_length == 10'd0)
      else $error("payload length shown on a hunting or preamble byte");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
      && $stable(rsp_byte_role))
      else $error("result beat changed while stalled");

   // a waiting input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte))
      else $error("input beat changed while waiting");

endmodule

bind rtcm3_frame_deframer_core r3df_checker u_r3df_checker (.*);

`default_nettype wire

FILE: tb/rtcm3_frame_deframer_checker.sv
// checker for the rtcm3 deframer: predicts each result beat and compares it on the rsp channel
module rtcm3_frame_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_echo_byte,
   input  logic [2:0]  rsp_byte_role,
   input  logic        rsp_frame_done,
   input  logic        rsp_crc_good,
   input  logic [11:0] rsp_message_type,
   input  logic        rsp_type_valid,
   input  logic [9:0]  rsp_frame_payload_length,
   output int          mismatch_count,
   output int          results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import r3df_pkg::*;

   phase_type   frame_phase;
   logic [23:0] running_crc;
   logic [23:0] trailer_crc;
   logic [9:0]  beat_count;
   logic [9:0]  frame_len;
   logic [11:0] type_field;

   result_type  expected_results[$];
   int          result_index;

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      result_index   = 0;
   end

   // bitwise crc-24q, msb first
   function automatic logic [23:0] crc24q_next(input logic [23:0] acc, input logic [7:0] b);
      logic [23:0] c;
      logic        feedback;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[23] ^ b[i];
         c = {c[22:0], 1'b0};
         if (feedback) begin
            c = c ^ CRC24Q_POLY[23:0];
         end
      end
      return c;
   endfunction

   function automatic void open_frame();
      frame_phase = PH_LEN_HI;
      running_crc = crc24q_next(24'h000000, PREAMBLE_BYTE);
      trailer_crc = '0;
      beat_count  = '0;
      frame_len   = '0;
      type_field  = '0;
   endfunction

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      r.echo_byte = b;
      case (frame_phase)
         PH_LEN_HI: begin
            if ((b & RESERVED_MASK) == 8'h00) begin
               r.byte_role = ROLE_LENGTH;
               frame_len   = {b[1:0], 8'h00};
               running_crc = crc24q_next(running_crc, b);
               frame_phase = PH_LEN_LO;
            end else if (b == PREAMBLE_BYTE) begin
               r.byte_role = ROLE_PREAMBLE;
               open_frame();
            end else begin
               r.byte_role = ROLE_DISCARD;
               frame_phase = PH_HUNT;
            end
         end
         PH_LEN_LO: begin
            r.byte_role = ROLE_LENGTH;
            frame_len   = {frame_len[9:8], b};
            running_crc = crc24q_next(running_crc, b);
            beat_count  = '0;
            frame_phase = (frame_len == 10'd0) ? PH_CRC : PH_PAYLOAD;
            r.frame_payload_length = frame_len;
         end
         PH_PAYLOAD: begin
            r.byte_role = ROLE_PAYLOAD;
            running_crc = crc24q_next(running_crc, b);
            if (beat_count == 10'd0) begin
               type_field = {b, 4'h0};
            end else if (beat_count == 10'd1) begin
               type_field = {type_field[11:4], b[7:4]};
            end
            beat_count = beat_count + 10'd1;
            if (beat_count >= frame_len) begin
               beat_count  = '0;
               frame_phase = PH_CRC;
            end
            r.frame_payload_length = frame_len;
         end
         PH_CRC: begin
            r.byte_role = ROLE_CRC;
            trailer_crc = {trailer_crc[15:0], b};
            beat_count  = beat_count + 10'd1;
            r.frame_payload_length = frame_len;
            if (beat_count >= TRAILER_LEN) begin
               r.frame_done   = 1'b1;
               r.crc_good     = (trailer_crc == running_crc);
               r.type_valid   = (frame_len >= TYPE_MIN_LEN);
               r.message_type = r.type_valid ? type_field : 12'h000;
               beat_count     = '0;
               frame_phase    = PH_HUNT;
            end
         end
         default: begin
            if (b == PREAMBLE_BYTE) begin
               r.byte_role = ROLE_PREAMBLE;
               open_frame();
            end else begin
               r.byte_role = ROLE_DISCARD;
               frame_phase = PH_HUNT;
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               result_index, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         frame_phase = PH_HUNT;
         running_crc = '0;
         trailer_crc = '0;
         beat_count  = '0;
         frame_len   = '0;
         type_field  = '0;
         expected_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(), deframe_byte(req_data_byte));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat, echo", 32'(rsp_echo_byte), 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_echo_byte !== want.echo_byte)
                  report_mismatch("echo_byte", 32'(rsp_echo_byte), 32'(want.echo_byte));
               if (rsp_byte_role !== want.byte_role)
                  report_mismatch("byte_role", 32'(rsp_byte_role), 32'(want.byte_role));
               if (rsp_frame_done !== want.frame_done)
                  report_mismatch("frame_done", 32'(rsp_frame_done),
                                  32'(want.frame_done));
               if (rsp_crc_good !== want.crc_good)
                  report_mismatch("crc_good", 32'(rsp_crc_good), 32'(want.crc_good));
               if (rsp_message_type !== want.message_type)
                  report_mismatch("message_type", 32'(rsp_message_type),
                                  32'(want.message_type));
               if (rsp_type_valid !== want.type_valid)
                  report_mismatch("type_valid", 32'(rsp_type_valid),
                                  32'(want.type_valid));
               if (rsp_frame_payload_length !== want.frame_payload_length)
                  report_mismatch("frame_payload_length", 32'(rsp_frame_payload_length),
                                  32'(want.frame_payload_length));
            end
            result_index++;
         end
      end
      results_owed = expected_results.size();
   end

endmodule

FILE: tb/tb_rtcm3_frame_deframer_core.sv
// testbench top for the rtcm3 deframer: byte stimulus, backpressure, watchdog and verdict
module tb_rtcm3_frame_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import r3df_pkg::*;

   localparam int RANDOM_ITEMS = 840;
   localparam int STALL_LIMIT  = 4000;   // cycles with no input beat
   localparam int TAIL_CYCLES  = 8;      // result latency plus margin
   localparam int MAX_LEN      = 1023;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_echo_byte;
   logic [2:0]  rsp_byte_role;
   logic        rsp_frame_done;
   logic        rsp_crc_good;
   logic [11:0] rsp_message_type;
   logic        rsp_type_valid;
   logic [9:0]  rsp_frame_payload_length;

   int mismatch_count;
   int results_owed;

   // idle odds in percent, changed per stimulus phase
   int send_idle_pct = 29;
   int recv_idle_pct = 83;
   int sent_items    = 0;

   rtcm3_frame_deframer_core i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_data_byte            (req_data_byte),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_echo_byte            (rsp_echo_byte),
      .rsp_byte_role            (rsp_byte_role),
      .rsp_frame_done           (rsp_frame_done),
      .rsp_crc_good             (rsp_crc_good),
      .rsp_message_type         (rsp_message_type),
      .rsp_type_valid           (rsp_type_valid),
      .rsp_frame_payload_length (rsp_frame_payload_length)
   );

   rtcm3_frame_deframer_checker i_checker (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_data_byte            (req_data_byte),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_echo_byte            (rsp_echo_byte),
      .rsp_byte_role            (rsp_byte_role),
      .rsp_frame_done           (rsp_frame_done),
      .rsp_crc_good             (rsp_crc_good),
      .rsp_message_type         (rsp_message_type),
      .rsp_type_valid           (rsp_type_valid),
      .rsp_frame_payload_length (rsp_frame_payload_length),
      .mismatch_count           (mismatch_count),
      .results_owed             (results_owed)
   );

   // 8 ns clock, low first so the first rising edge sees reset already high
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // receiver backpressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // one byte beat on req_; entered and left at a falling edge
   // valid stays high into the next beat unless the sender idles
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_items++;
      @(negedge clock);
   endtask

   // builds preamble, length, payload and big-endian crc-24q, then sends the first
   // keep bytes of it (all when keep is 0); corrupt flips one bit past the header
   task automatic send_frame(input int unsigned len, input bit corrupt,
                             input int unsigned keep);
      logic [7:0]  frame_bytes[$];
      logic [23:0] crc;
      int unsigned flip_at;
      int unsigned last;
      frame_bytes = {frame_bytes, PREAMBLE_BYTE};
      frame_bytes = {frame_bytes, {6'b000000, 2'(len >> 8)}};
      frame_bytes = {frame_bytes, 8'(len)};
      for (int unsigned i = 0; i < len; i++) begin
         frame_bytes = {frame_bytes, 8'($urandom_range(255))};
      end
      crc = 24'h000000;
      foreach (frame_bytes[i]) begin
         crc = crc24q_byte(crc, frame_bytes[i]);
      end
      frame_bytes = {frame_bytes, crc[23:16]};
      frame_bytes = {frame_bytes, crc[15:8]};
      frame_bytes = {frame_bytes, crc[7:0]};
      if (corrupt) begin
         flip_at = $urandom_range(frame_bytes.size() - 1, 3);
         frame_bytes[flip_at] = frame_bytes[flip_at] ^ 8'(1 << $urandom_range(7));
      end
      last = (keep == 0 || keep > frame_bytes.size()) ? frame_bytes.size() : keep;
      for (int unsigned i = 0; i < last; i++) begin
         send_byte(frame_bytes[i]);
      end
   endtask

   // one random stretch of traffic: mostly well-formed frames, some noise,
   // broken headers and truncated frames
   task automatic send_random_traffic(input int unsigned item_goal);
      int unsigned pick;
      int unsigned len;
      while (sent_items < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // line noise while hunting
            send_byte(8'($urandom_range(255)));
         end else if (pick < 16) begin
            // preamble followed by a header byte that is usually rejected
            send_byte(PREAMBLE_BYTE);
            send_byte(($urandom_range(3) == 0) ? PREAMBLE_BYTE : 8'($urandom_range(255)));
         end else if (pick < 20) begin
            // frame cut short, the next bytes get swallowed as its payload
            len = $urandom_range(20);
            send_frame(len, 1'b0, $urandom_range(len + 5, 1));
         end else begin
            pick = $urandom_range(99);
            if (pick < 90) begin
               len = $urandom_range(20);
            end else if (pick < 98) begin
               len = $urandom_range(200);
            end else begin
               len = $urandom_range(400, 256);
            end
            send_frame(len, ($urandom_range(99) < 20), 0);
         end
      end
   endtask

   // watchdog: ends the run when no input beat is taken for too long
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int unsigned goal;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: byte extremes while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // preamble twice restarts the frame, then a reserved-bit header is rejected
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      send_byte(RESERVED_MASK);
      // empty payload goes straight to crc, one-byte payload gives no type
      send_frame(0, 1'b0, 0);
      send_frame(1, 1'b0, 0);
      // two-byte payload with a broken crc, then hunting resumes
      send_frame(2, 1'b1, 0);

      // random phase one: sender idles lightly, receiver heavily
      goal = sent_items + RANDOM_ITEMS / 3;
      send_random_traffic(goal);

      // random phase two: the other way round
      send_idle_pct = 83;
      recv_idle_pct = 29;
      goal = sent_items + RANDOM_ITEMS / 3;
      send_random_traffic(goal);

      // random phase three: no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      goal = sent_items + RANDOM_ITEMS / 3;
      send_random_traffic(goal);

      // longest payload, covers the top length bits
      send_frame(MAX_LEN, 1'b0, 0);
      send_byte(8'h00);

      req_valid = 1'b0;

      // drain: all results back, then a tail wait for any stray beat
      while (results_owed != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: rtcm3_frame_deframer_core.f
rtl/r3df_pkg.sv
rtl/r3df_parser.sv
rtl/r3df_out_reg.sv
rtl/rtcm3_frame_deframer_core.sv
rtl/r3df_checker.sv
tb/rtcm3_frame_deframer_checker.sv
tb/tb_rtcm3_frame_deframer_core.sv
